// ===== src/lft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lft_pkg
// Shared types, token kinds and character decoders for the formula tokenizer.
// ----------------------------------------------------------------------------
package lft_pkg;

	localparam int QDEPTH = 4;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	localparam logic [5:0] K_IDENT    = 6'd0;
	localparam logic [5:0] K_OR       = 6'd1;
	localparam logic [5:0] K_VAR      = 6'd2;
	localparam logic [5:0] K_EX1      = 6'd3;
	localparam logic [5:0] K_AT1      = 6'd4;
	localparam logic [5:0] K_TRUE     = 6'd5;
	localparam logic [5:0] K_FALSE    = 6'd6;
	localparam logic [5:0] K_INIT     = 6'd7;
	localparam logic [5:0] K_INF      = 6'd8;
	localparam logic [5:0] K_TYPE     = 6'd9;
	localparam logic [5:0] K_NUMBER   = 6'd10;
	localparam logic [5:0] K_FLOAT    = 6'd11;
	localparam logic [5:0] K_VARIABLE = 6'd12;
	localparam logic [5:0] K_IMPLIES  = 6'd13;
	localparam logic [5:0] K_DIAMOND  = 6'd14;
	localparam logic [5:0] K_NOT      = 6'd15;
	localparam logic [5:0] K_LBRACKET = 6'd16;
	localparam logic [5:0] K_RBRACKET = 6'd17;
	localparam logic [5:0] K_LBRACE   = 6'd18;
	localparam logic [5:0] K_RBRACE   = 6'd19;
	localparam logic [5:0] K_STAR     = 6'd20;
	localparam logic [5:0] K_LPAREN   = 6'd21;
	localparam logic [5:0] K_RPAREN   = 6'd22;
	localparam logic [5:0] K_AND      = 6'd23;
	localparam logic [5:0] K_COMMA    = 6'd24;
	localparam logic [5:0] K_COLON    = 6'd25;
	localparam logic [5:0] K_SEMI     = 6'd26;
	localparam logic [5:0] K_AT       = 6'd27;
	localparam logic [5:0] K_EQUALS   = 6'd28;
	localparam logic [5:0] K_LESS     = 6'd29;
	localparam logic [5:0] K_GREATER  = 6'd30;
	localparam logic [5:0] K_ENDLINE  = 6'd31;
	localparam logic [5:0] K_UNKNOWN  = 6'd32;

	typedef enum logic [7:0] {
		MODE_IDLE     = 8'b0000_0001,
		MODE_IDENT    = 8'b0000_0010,
		MODE_NUMBER   = 8'b0000_0100,
		MODE_VARIABLE = 8'b0000_1000,
		MODE_COMMENT  = 8'b0001_0000,
		MODE_MINUS    = 8'b0010_0000,
		MODE_EQUAL    = 8'b0100_0000,
		MODE_LESS     = 8'b1000_0000
	} scan_mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] length;
	} token_t;

	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} bundle_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// only the first five characters are kept; the count decides the match
	function automatic logic [5:0] keyword_kind(input logic [39:0] pre, input logic [15:0] cnt);
		logic [5:0] k;
		k = K_IDENT;
		if (cnt == 16'd1 && pre == 40'("v"))     k = K_OR;
		if (cnt == 16'd3 && pre == 40'("var"))   k = K_VAR;
		if (cnt == 16'd3 && pre == 40'("ex1"))   k = K_EX1;
		if (cnt == 16'd3 && pre == 40'("at1"))   k = K_AT1;
		if (cnt == 16'd4 && pre == 40'("true"))  k = K_TRUE;
		if (cnt == 16'd5 && pre == 40'("false")) k = K_FALSE;
		if (cnt == 16'd4 && pre == 40'("init"))  k = K_INIT;
		if (cnt == 16'd3 && pre == 40'("inf"))   k = K_INF;
		if (cnt == 16'd4 && pre == 40'("type"))  k = K_TYPE;
		return k;
	endfunction

	function automatic logic [5:0] symbol_kind(input logic [7:0] c);
		logic [5:0] k;
		unique case (c)
			"!", "~": k = K_NOT;
			"[":      k = K_LBRACKET;
			"]":      k = K_RBRACKET;
			"{":      k = K_LBRACE;
			"}":      k = K_RBRACE;
			"*":      k = K_STAR;
			"(":      k = K_LPAREN;
			")":      k = K_RPAREN;
			"^", "&": k = K_AND;
			"|":      k = K_OR;
			",":      k = K_COMMA;
			":":      k = K_COLON;
			";":      k = K_SEMI;
			"@":      k = K_AT;
			">":      k = K_GREATER;
			default:  k = K_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== src/lft_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lft_front
// Scanner: takes one character per cycle while the queue has space, tracks
// position and pending token, and queues every token group a character causes.
// ----------------------------------------------------------------------------
module lft_front #(
	parameter int POSITION_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             space,
	input  wire logic [7:0]       char_code,
	input  wire logic             end_of_input,
	output logic                  push,
	output lft_pkg::bundle_t      bundle
);
	import lft_pkg::*;

	localparam int PW = POSITION_WIDTH;

	scan_mode_t    mode_q, mode_d;
	logic [PW-1:0] line_q, line_d, col_q, col_d, sl_q, sl_d, sc_q, sc_d;
	logic [15:0]   cnt_q, cnt_d;
	logic [39:0]   pre_q, pre_d;
	logic          dot_q, dot_d;

	logic          in_fire, pend_has, pend_v, new_v, cont, op2;
	logic [PW-1:0] col_inc;
	logic [15:0]   cnt_inc;
	token_t        pend_tok, new_tok;

	function automatic logic [15:0] clamp_pos(input logic [PW-1:0] v);
		logic [32:0] e;
		e = 33'(v);
		return (e > 33'h0_FFFF) ? 16'hFFFF : e[15:0];
	endfunction

	function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
		return (v == {PW{1'b1}}) ? v : v + PW'(1);
	endfunction

	assign in_fire = in_valid && space;
	assign col_inc = sat_inc(col_q);
	assign cnt_inc = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;

	always_comb begin
		pend_has = 1'b1;
		pend_tok.line   = clamp_pos(sl_q);
		pend_tok.column = clamp_pos(sc_q);
		pend_tok.length = cnt_q;
		unique case (mode_q)
			MODE_IDENT:    pend_tok.kind = keyword_kind(pre_q, cnt_q);
			MODE_NUMBER:   pend_tok.kind = dot_q ? K_FLOAT : K_NUMBER;
			MODE_VARIABLE: pend_tok.kind = K_VARIABLE;
			MODE_MINUS: begin
				pend_tok.kind   = K_UNKNOWN;
				pend_tok.length = 16'd1;
			end
			MODE_EQUAL: begin
				pend_tok.kind   = K_EQUALS;
				pend_tok.length = 16'd1;
			end
			MODE_LESS: begin
				pend_tok.kind   = K_LESS;
				pend_tok.length = 16'd1;
			end
			default: begin
				pend_has      = 1'b0;
				pend_tok.kind = K_IDENT;
			end
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		line_d  = line_q;
		col_d   = col_q;
		sl_d    = sl_q;
		sc_d    = sc_q;
		cnt_d   = cnt_q;
		pre_d   = pre_q;
		dot_d   = dot_q;
		pend_v  = 1'b0;
		new_v   = 1'b0;
		cont    = 1'b0;
		op2     = 1'b0;
		new_tok.kind   = symbol_kind(char_code);
		new_tok.line   = clamp_pos(line_q);
		new_tok.column = clamp_pos(col_inc);
		new_tok.length = 16'd1;
		if (in_fire) begin
			if (end_of_input) begin
				pend_v = pend_has;
				mode_d = MODE_IDLE;
				line_d = PW'(1);
				col_d  = '0;
				sl_d   = '0;
				sc_d   = '0;
				cnt_d  = '0;
				pre_d  = '0;
				dot_d  = 1'b0;
			end else begin
				col_d = col_inc;
				unique case (mode_q)
					MODE_IDENT: begin
						if (is_alpha(char_code) || is_digit(char_code) || char_code == "-") begin
							cont = 1'b1;
							if (cnt_q < 16'd5) pre_d = {pre_q[31:0], char_code};
							cnt_d = cnt_inc;
						end
					end
					MODE_NUMBER: begin
						if (is_digit(char_code) || char_code == ".") begin
							cont  = 1'b1;
							dot_d = dot_q || (char_code == ".");
							cnt_d = cnt_inc;
						end
					end
					MODE_VARIABLE: begin
						if (is_alpha(char_code) || is_digit(char_code)) begin
							cont  = 1'b1;
							cnt_d = cnt_inc;
						end
					end
					MODE_COMMENT: begin
						cont = (char_code != CH_NL);
					end
					MODE_MINUS, MODE_EQUAL, MODE_LESS: begin
						op2 = (char_code == ">");
					end
					default: ;
				endcase
				if (op2) begin
					new_v          = 1'b1;
					new_tok.kind   = (mode_q == MODE_LESS) ? K_DIAMOND : K_IMPLIES;
					new_tok.line   = clamp_pos(sl_q);
					new_tok.column = clamp_pos(sc_q);
					new_tok.length = 16'd2;
					mode_d         = MODE_IDLE;
				end else if (!cont) begin
					pend_v = pend_has;
					mode_d = MODE_IDLE;
					if (is_alpha(char_code)) begin
						mode_d = MODE_IDENT;
						sl_d   = line_q;
						sc_d   = col_inc;
						cnt_d  = 16'd1;
						pre_d  = 40'(char_code);
					end else if (is_digit(char_code) || char_code == ".") begin
						mode_d = MODE_NUMBER;
						sl_d   = line_q;
						sc_d   = col_inc;
						cnt_d  = 16'd1;
						dot_d  = (char_code == ".");
					end else if (char_code == "?" || char_code == "-" ||
							char_code == "=" || char_code == "<") begin
						sl_d  = line_q;
						sc_d  = col_inc;
						cnt_d = (char_code == "?") ? 16'd0 : 16'd1;
						if (char_code == "?")      mode_d = MODE_VARIABLE;
						else if (char_code == "-") mode_d = MODE_MINUS;
						else if (char_code == "=") mode_d = MODE_EQUAL;
						else                       mode_d = MODE_LESS;
					end else if (char_code == "#") begin
						mode_d = MODE_COMMENT;
					end else if (char_code == " " || char_code == CH_TAB ||
							char_code == CH_CR) begin
						mode_d = MODE_IDLE;
					end else if (char_code == CH_NL) begin
						new_v        = 1'b1;
						new_tok.kind = K_ENDLINE;
						line_d       = sat_inc(line_q);
						col_d        = '0;
					end else begin
						new_v = 1'b1;
					end
				end
			end
		end
	end

	assign push        = pend_v || new_v;
	assign bundle.two  = pend_v && new_v;
	assign bundle.tok0 = pend_v ? pend_tok : new_tok;
	assign bundle.tok1 = new_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= PW'(1);
			col_q  <= '0;
			sl_q   <= '0;
			sc_q   <= '0;
			cnt_q  <= '0;
			pre_q  <= '0;
			dot_q  <= 1'b0;
		end else begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
			sl_q   <= sl_d;
			sc_q   <= sc_d;
			cnt_q  <= cnt_d;
			pre_q  <= pre_d;
			dot_q  <= dot_d;
		end
	end

	a_eoi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && end_of_input |=> mode_q == MODE_IDLE && line_q == PW'(1) && col_q == '0)
		else $error("stream end did not restore scanner state");

	a_op2_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		op2 |-> !pend_v && push && !bundle.two)
		else $error("two-character operator with extra token");

	a_comment_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !end_of_input && mode_q == MODE_COMMENT && char_code != CH_NL |-> !push)
		else $error("comment produced a token");

endmodule
`default_nettype wire

// ===== src/lft_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lft_queue
// Short FIFO of token groups between scanner and output stage.
// ----------------------------------------------------------------------------
module lft_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lft_pkg::bundle_t wdata,
	output logic                  space,
	input  wire logic             pop,
	output logic                  nonempty,
	output lft_pkg::bundle_t      rdata
);
	import lft_pkg::*;

	localparam int PTRW = $clog2(QDEPTH);

	bundle_t         mem_q [QDEPTH];
	logic [PTRW-1:0] wr_q, rd_q;
	logic [PTRW:0]   cnt_q;

	assign space    = cnt_q != (PTRW+1)'(QDEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTRW'(1);
			if (pop)  rd_q <= rd_q + PTRW'(1);
			if (push && !pop)      cnt_q <= cnt_q + (PTRW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PTRW+1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> space)
		else $error("request written into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("request read from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTRW+1)'(QDEPTH))
		else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== src/lft_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lft_back
// Output stage: unpacks token groups into single results and marks the last.
// ----------------------------------------------------------------------------
module lft_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             nonempty,
	input  wire lft_pkg::bundle_t rdata,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output lft_pkg::token_t       out_tok,
	output logic                  out_last
);
	import lft_pkg::*;

	logic   valid_q, last_q, sec_q;
	token_t tok_q, sec_tok_q;
	logic   load;

	assign load      = !valid_q || out_ready;
	assign pop       = load && !sec_q && nonempty;
	assign out_valid = valid_q;
	assign out_tok   = tok_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (load && sec_q) begin
			tok_q <= sec_tok_q;
		end else if (pop) begin
			tok_q     <= rdata.tok0;
			sec_tok_q <= rdata.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			sec_q   <= 1'b0;
		end else if (load) begin
			if (sec_q) begin
				valid_q <= 1'b1;
				last_q  <= 1'b1;
				sec_q   <= 1'b0;
			end else begin
				valid_q <= nonempty;
				last_q  <= !rdata.two;
				sec_q   <= nonempty && rdata.two;
			end
		end
	end

	a_sec_behind_first: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q |-> valid_q && !last_q)
		else $error("second token held without a first one shown");

	a_no_pop_while_sec: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q |-> !pop)
		else $error("new request taken before second token sent");

	a_sec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q && out_ready |=> valid_q && last_q)
		else $error("second token not presented after first");

endmodule
`default_nettype wire

// ===== src/logic_formula_tokenizer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// logic_formula_tokenizer_top
// Character-stream tokenizer for logic formulas: scanner, token queue, output.
// ----------------------------------------------------------------------------
// Path: the first token of a character goes through the group queue to the
//   output register; a second token follows from the second-token register.
// Throughput: one character per cycle while in_ready; one token out per cycle
//   while out_ready; the 4-entry group queue absorbs two-token characters.
// Reset: arst_n clears scanner state to line 1, column 0, and empties queue
//   and output stage; end_of_input does the same to the scanner in-band.
// ----------------------------------------------------------------------------
module logic_formula_tokenizer_top #(
	parameter int POSITION_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_input,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       token_kind,
	output logic [15:0]      start_line,
	output logic [15:0]      start_column,
	output logic [15:0]      token_length,
	output logic             last
);
	import lft_pkg::*;

	logic    space, push, pop, nonempty;
	bundle_t wbundle, rbundle;
	token_t  tok;

	lft_front #(.POSITION_WIDTH(POSITION_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.space        (space),
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.push         (push),
		.bundle       (wbundle)
	);

	lft_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (wbundle),
		.space    (space),
		.pop      (pop),
		.nonempty (nonempty),
		.rdata    (rbundle)
	);

	lft_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nonempty  (nonempty),
		.rdata     (rbundle),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_tok   (tok),
		.out_last  (last)
	);

	assign in_ready     = space;
	assign token_kind   = tok.kind;
	assign start_line   = tok.line;
	assign start_column = tok.column;
	assign token_length = tok.length;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the formula tokenizer. Characters go in over a
// valid/ready request channel; a scanner model in the bench predicts every
// token, which is compared field by field with what comes out. Directed
// sequences cover all token kinds, paired operators, comments and flushes.
// A backpressure test holds one long output stall; a random part follows,
// with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import lft_pkg::*;

	localparam int          CYCLE_LIMIT   = 1_000_000;
	localparam int          RANDOM_ITEMS  = 280;
	localparam int          HOLD_CYCLES   = 200;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          NUM_KEYWORDS  = 9;
	localparam logic [15:0] POS_MAX       = 16'hFFFF;
	localparam logic [15:0] LEN_MAX       = 16'hFFFF;

	localparam string LETTERS    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	localparam string VAR_CHARS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789-";
	localparam string NUM_CHARS  = "0123456789..";
	localparam string SYMBOLS    = "!~[]{}*()^&|,:;@>";

	typedef struct packed {
		token_t tok;
		logic   last;
	} expected_token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code = 8'h00;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  token_kind;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [15:0] token_length;
	logic        last;

	string      keyword_text[NUM_KEYWORDS] = '{"v", "var", "ex1", "at1", "true", "false",
		"init", "inf", "type"};
	logic [5:0] keyword_code[NUM_KEYWORDS] = '{K_OR, K_VAR, K_EX1, K_AT1, K_TRUE, K_FALSE,
		K_INIT, K_INF, K_TYPE};

	// scanner model state
	scan_mode_t  scan_state;
	logic [15:0] cur_line;
	logic [15:0] cur_col;
	logic [15:0] tok_line;
	logic [15:0] tok_col;
	logic [15:0] tok_len;
	logic [39:0] word_prefix;
	logic        has_dot;

	expected_token_t step_out[2];
	int              step_n;
	expected_token_t predicted_tokens[$];

	bit tx_idle_en   = 1'b0;
	bit rx_idle_en   = 1'b0;
	bit hold_pending = 1'b0;
	int cycle_count  = 0;
	int error_count  = 0;
	int chars_sent   = 0;
	int active_chars = 0;
	int flushes      = 0;
	int tokens_seen  = 0;

	logic_formula_tokenizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.start_line(start_line),
		.start_column(start_column),
		.token_length(token_length),
		.last(last)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
				predicted_tokens.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// scanner model
	// ------------------------------------------------------------------
	function automatic logic ident_start(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic decimal(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [5:0] word_kind(input logic [39:0] prefix, input logic [15:0] count);
		logic [39:0] text;
		logic [5:0]  kind;
		kind = K_IDENT;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			text = '0;
			for (int i = 0; i < keyword_text[k].len(); i++)
				text = {text[31:0], keyword_text[k][i]};
			if (keyword_text[k].len() == count && text == prefix)
				kind = keyword_code[k];
		end
		return kind;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		case (c)
			"!", "~": return K_NOT;
			"[":      return K_LBRACKET;
			"]":      return K_RBRACKET;
			"{":      return K_LBRACE;
			"}":      return K_RBRACE;
			"*":      return K_STAR;
			"(":      return K_LPAREN;
			")":      return K_RPAREN;
			"^", "&": return K_AND;
			"|":      return K_OR;
			",":      return K_COMMA;
			":":      return K_COLON;
			";":      return K_SEMI;
			"@":      return K_AT;
			">":      return K_GREATER;
			default:  return K_UNKNOWN;
		endcase
	endfunction

	function automatic void note_token(input logic [5:0] kind, input logic [15:0] line,
		input logic [15:0] col, input logic [15:0] len);
		step_out[step_n].tok.kind   = kind;
		step_out[step_n].tok.line   = line;
		step_out[step_n].tok.column = col;
		step_out[step_n].tok.length = len;
		step_out[step_n].last       = 1'b0;
		step_n++;
	endfunction

	function automatic void restart_stream();
		scan_state  = MODE_IDLE;
		cur_line    = 16'd1;
		cur_col     = 16'd0;
		tok_line    = 16'd0;
		tok_col     = 16'd0;
		tok_len     = 16'd0;
		word_prefix = '0;
		has_dot     = 1'b0;
	endfunction

	function automatic void flush_token();
		case (scan_state)
			MODE_IDENT:    note_token(word_kind(word_prefix, tok_len), tok_line, tok_col, tok_len);
			MODE_NUMBER:   note_token(has_dot ? K_FLOAT : K_NUMBER, tok_line, tok_col, tok_len);
			MODE_VARIABLE: note_token(K_VARIABLE, tok_line, tok_col, tok_len);
			MODE_MINUS:    note_token(K_UNKNOWN, tok_line, tok_col, 16'd1);
			MODE_EQUAL:    note_token(K_EQUALS, tok_line, tok_col, 16'd1);
			MODE_LESS:     note_token(K_LESS, tok_line, tok_col, 16'd1);
			default: ;
		endcase
		scan_state = MODE_IDLE;
	endfunction

	function automatic void open_mode(input scan_mode_t mode, input logic [15:0] len);
		scan_state = mode;
		tok_line   = cur_line;
		tok_col    = cur_col;
		tok_len    = len;
	endfunction

	function automatic void open_token(input logic [7:0] c);
		if (ident_start(c)) begin
			open_mode(MODE_IDENT, 16'd1);
			word_prefix = {32'd0, c};
		end else if (decimal(c) || c == ".") begin
			open_mode(MODE_NUMBER, 16'd1);
			has_dot = (c == ".");
		end else if (c == "?") begin
			open_mode(MODE_VARIABLE, 16'd0);
		end else if (c == "-") begin
			open_mode(MODE_MINUS, 16'd1);
		end else if (c == "=") begin
			open_mode(MODE_EQUAL, 16'd1);
		end else if (c == "<") begin
			open_mode(MODE_LESS, 16'd1);
		end else if (c == "#") begin
			scan_state = MODE_COMMENT;
		end else if (c == CH_NL) begin
			note_token(K_ENDLINE, cur_line, cur_col, 16'd1);
			if (cur_line != POS_MAX)
				cur_line++;
			cur_col = 16'd0;
		end else if (c != " " && c != CH_TAB && c != CH_CR) begin
			note_token(single_kind(c), cur_line, cur_col, 16'd1);
		end
	endfunction

	function automatic void scan_char(input logic [7:0] c, input logic eoi);
		logic taken;
		step_n = 0;
		if (eoi) begin
			flush_token();
			restart_stream();
		end else begin
			taken = 1'b0;
			if (cur_col != POS_MAX)
				cur_col++;
			case (scan_state)
				MODE_IDENT: if (ident_start(c) || decimal(c) || c == "-") begin
					if (tok_len < 16'd5)
						word_prefix = {word_prefix[31:0], c};
					taken = 1'b1;
				end
				MODE_NUMBER: if (decimal(c) || c == ".") begin
					if (c == ".")
						has_dot = 1'b1;
					taken = 1'b1;
				end
				MODE_VARIABLE: taken = ident_start(c) || decimal(c);
				MODE_COMMENT:  taken = (c != CH_NL);
				MODE_MINUS, MODE_EQUAL, MODE_LESS: if (c == ">") begin
					note_token(scan_state == MODE_LESS ? K_DIAMOND : K_IMPLIES, tok_line, tok_col,
						16'd2);
					scan_state = MODE_IDLE;
					taken = 1'b1;
				end
				default: ;
			endcase
			if (taken && scan_state != MODE_COMMENT && scan_state != MODE_IDLE &&
				tok_len != LEN_MAX)
				tok_len++;
			if (!taken) begin
				flush_token();
				open_token(c);
			end
		end
		for (int i = 0; i < step_n; i++) begin
			step_out[i].last = (i == step_n - 1);
			predicted_tokens.insert(predicted_tokens.size(), step_out[i]);
		end
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	task automatic send_char(input logic [7:0] c, input logic eoi = 1'b0);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		char_code    <= c;
		end_of_input <= eoi;
		do
			@(posedge clk);
		while (!in_ready);
		scan_char(c, eoi);
		chars_sent++;
		if (eoi)
			flushes++;
		if (eoi || (c != " " && c != CH_TAB && c != CH_CR))
			active_chars++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_end();
		send_char(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic wait_tokens_out();
		in_valid <= 1'b0;
		while (predicted_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_char(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	initial begin : sink
		int hold;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = 0;
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold = HOLD_CYCLES;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 9);
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		expected_token_t want;
		if (arst_n && out_valid && out_ready) begin
			tokens_seen++;
			if (predicted_tokens.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected token: kind %0d at %0d:%0d len %0d last %0b",
						token_kind, start_line, start_column, token_length, last);
			end else begin
				want = predicted_tokens.pop_front();
				if (token_kind !== want.tok.kind || start_line !== want.tok.line ||
					start_column !== want.tok.column || token_length !== want.tok.length ||
					last !== want.last) begin
					error_count++;
					if (error_count <= 10)
						$display({"token %0d mismatch: exp kind %0d at %0d:%0d len %0d last %0b,",
							" got kind %0d at %0d:%0d len %0d last %0b"}, tokens_seen,
							want.tok.kind, want.tok.line, want.tok.column, want.tok.length,
							want.last, token_kind, start_line, start_column, token_length, last);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_symbols();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_text(SYMBOLS);
		send_char(CH_NL);
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h80);
		send_char("$");
		send_char("%");
		wait_tokens_out();
	endtask

	task automatic test_words();
		send_text("v var ex1 at1 true false init inf type\n");
		send_text("falsey tru in-f _x9 Z-0- typeX\n");
		send_text("?x ?_a1 ? ?9z ?q-1 3 3.14 . 1.2.3 007\n");
		wait_tokens_out();
	endtask

	task automatic test_operators();
		send_text("a->b=>c<>d - = < -( =( <( -- == << =<> a!b(c)\n");
		send_char(CH_TAB);
		send_char(CH_CR);
		send_text("x|y\n");
		wait_tokens_out();
	endtask

	task automatic test_comments();
		send_text("x#note -> y\n#\n  # tail");
		send_char(8'hA5);
		send_char(8'h00);
		send_end();
		wait_tokens_out();
	endtask

	task automatic test_end_of_input();
		send_text("abc");
		send_end();
		send_text("12.");
		send_end();
		send_text("?v");
		send_end();
		send_text("?");
		send_end();
		send_text("-");
		send_end();
		send_text("=");
		send_end();
		send_text("<");
		send_end();
		send_end();
		send_text("false");
		send_end();
		send_text("x\ny");
		send_end();
		wait_tokens_out();
	endtask

	task automatic test_backpressure();
		tx_idle_en   = 1'b0;
		rx_idle_en   = 1'b0;
		hold_pending = 1'b1;
		repeat (30) send_text("a(");
		send_end();
		wait_tokens_out();
	endtask

	task automatic test_random();
		int         target;
		int         left;
		int         pick;
		int         k;
		logic [7:0] c;
		logic [7:0] lexeme[$];
		target = active_chars + RANDOM_ITEMS;
		while (active_chars < target) begin
			left = target - active_chars;
			tx_idle_en = (left > 60) && !(left > 160 && left < 190);
			rx_idle_en = tx_idle_en;
			lexeme.delete();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				k = $urandom_range(0, NUM_KEYWORDS - 1);
				for (int i = 0; i < keyword_text[k].len(); i++)
					lexeme.insert(lexeme.size(), keyword_text[k][i]);
				if (pick < 2 && lexeme.size() > 1)
					void'(lexeme.pop_back());
				else if ($urandom_range(0, 2) == 0)
					lexeme.insert(lexeme.size(), pick_char(WORD_CHARS));
			end else if (pick < 22) begin
				lexeme.insert(lexeme.size(), pick_char(LETTERS));
				repeat ($urandom_range(0, 7)) lexeme.insert(lexeme.size(), pick_char(WORD_CHARS));
			end else if (pick < 32) begin
				repeat ($urandom_range(1, 6)) lexeme.insert(lexeme.size(), pick_char(NUM_CHARS));
			end else if (pick < 40) begin
				lexeme.insert(lexeme.size(), "?");
				repeat ($urandom_range(0, 5)) lexeme.insert(lexeme.size(), pick_char(VAR_CHARS));
			end else if (pick < 52) begin
				case ($urandom_range(0, 5))
					0: begin lexeme.insert(lexeme.size(), "-"); lexeme.insert(lexeme.size(), ">"); end
					1: begin lexeme.insert(lexeme.size(), "="); lexeme.insert(lexeme.size(), ">"); end
					2: begin lexeme.insert(lexeme.size(), "<"); lexeme.insert(lexeme.size(), ">"); end
					3: lexeme.insert(lexeme.size(), "-");
					4: lexeme.insert(lexeme.size(), "=");
					default: lexeme.insert(lexeme.size(), "<");
				endcase
			end else if (pick < 68) begin
				lexeme.insert(lexeme.size(), pick_char(SYMBOLS));
			end else if (pick < 76) begin
				lexeme.insert(lexeme.size(), CH_NL);
			end else if (pick < 80) begin
				lexeme.insert(lexeme.size(), "#");
				repeat ($urandom_range(0, 8)) begin
					c = 8'($urandom_range(0, 255));
					lexeme.insert(lexeme.size(), c == CH_NL ? 8'h20 : c);
				end
				if ($urandom_range(0, 1) == 0)
					lexeme.insert(lexeme.size(), CH_NL);
			end else if (pick < 88) begin
				lexeme.insert(lexeme.size(), 8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				send_end();
			end else begin
				case ($urandom_range(0, 2))
					0: lexeme.insert(lexeme.size(), " ");
					1: lexeme.insert(lexeme.size(), CH_TAB);
					default: lexeme.insert(lexeme.size(), CH_CR);
				endcase
			end
			foreach (lexeme[i])
				send_char(lexeme[i]);
			if ($urandom_range(0, 1) == 0)
				send_char(" ");
		end
		send_end();
		wait_tokens_out();
	endtask

	initial begin
		restart_stream();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_symbols();
		test_words();
		test_operators();
		test_comments();
		test_end_of_input();
		test_backpressure();
		test_random();
		$display("Checked %0d tokens from %0d characters and %0d end-of-input flushes.",
			tokens_seen, chars_sent, flushes);
		$display("Covered all token kinds, paired operators, comments, flushes, output stall.");
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d token mismatches", error_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
